// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define LFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");

// Next-cycle implication
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ===== hdl/lfr_pkg.sv =====
// Shared types and constants for the logic function registry.
// No dependencies; imported by every module of the block.
package lfr_pkg;

  localparam int MAX_INPUTS   = 6;
  localparam int TABLE_DEPTH  = 1024;
  // Must be a power of two: the bucket index is a BKT_W-bit fold of the hash.
  localparam int BUCKET_COUNT = 1024;
  localparam int QUEUE_DEPTH  = 4;

  localparam int TT_W    = 64;
  localparam int ARITY_W = 3;
  localparam int GT_W    = 4;
  localparam int FID_W   = 10;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;

  localparam int ID_W   = $clog2(TABLE_DEPTH);
  localparam int LINK_W = ID_W + 1;
  localparam int BKT_W  = $clog2(BUCKET_COUNT);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [LINK_W-1:0] NIL_LINK = '1;

  localparam logic [TT_W-1:0] PARITY64 = 64'h6996966996696996;
  localparam logic [TT_W-1:0] MUL_N    = 64'h9E3779B97F4A7C15;
  localparam logic [TT_W-1:0] MUL_H    = 64'hD6E8FEB86659FD93;

  typedef enum logic [GT_W-1:0] {
    G_CONST0  = 4'd0,
    G_CONST1  = 4'd1,
    G_BUFF    = 4'd2,
    G_NOT     = 4'd3,
    G_AND     = 4'd4,
    G_NAND    = 4'd5,
    G_OR      = 4'd6,
    G_NOR     = 4'd7,
    G_XOR     = 4'd8,
    G_XNOR    = 4'd9,
    G_COMPLEX = 4'd10
  } gate_t;

  typedef struct packed {
    logic [TT_W-1:0]    tt;
    logic [ARITY_W-1:0] n;
    gate_t              gtype;
  } lfr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lfr_qstat_t;

endpackage

// ===== hdl/logic_function_registry_unit.sv =====
// Logic function registry: classifies truth tables and assigns ids to complex functions.
// A simple gate's result is registered when it is popped; a complex function runs the hash
// multiply, the bucket read, the chain walk and, on a miss, an insert, in that order.
// Throughput: one simple gate per cycle while the queue holds requests and the output is
// accepted; a complex one holds the back end, and no request is popped, until its result is registered.
// Reset: synchronous; a clearing pass then writes NIL_LINK to every bucket head, in_tready low.
module logic_function_registry_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] truth_table, [66:64] num_inputs, [71:67] zero
  input  logic [lfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] gate_type, [13:4] func_id, [14] id_valid, [15] table_full
  output logic [lfr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lfr_pkg::*;

  lfr_item_t  push_item;
  lfr_item_t  head_item;
  lfr_qstat_t qstat;
  logic       push;
  logic       pop;
  logic       clearing;

  lfr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .clearing  (clearing),
    .qstat     (qstat),
    .push      (push),
    .item      (push_item)
  );

  lfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (push_item),
    .pop      (pop),
    .item_out (head_item),
    .stat     (qstat)
  );

  lfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .item       (head_item),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/lfr_front.sv =====
// Front end: accepts requests, masks the table to its input count and classifies it.
// Depends on lfr_pkg.
module lfr_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lfr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          clearing,
  input  lfr_pkg::lfr_qstat_t           qstat,
  output logic                          push,
  output lfr_pkg::lfr_item_t            item
);
  import lfr_pkg::*;

  logic [ARITY_W-1:0] n_raw;
  logic [ARITY_W-1:0] n_clamp;
  logic [TT_W-1:0]    mask;
  logic [TT_W-1:0]    tt;

  function automatic gate_t classify(input logic [TT_W-1:0] t,
                                     input logic [ARITY_W-1:0] n,
                                     input logic [TT_W-1:0] m);
    logic [TT_W-1:0] top;
    logic [TT_W-1:0] par;
    gate_t           g;
    top = m ^ (m >> 1);
    par = PARITY64 & m;
    if (t == '0)                          g = G_CONST0;
    else if (t == m)                      g = G_CONST1;
    else if (n == ARITY_W'(1))            g = (t == TT_W'(2)) ? G_BUFF : G_NOT;
    else if (t == top)                    g = G_AND;
    else if (t == (m ^ top))              g = G_NAND;
    else if (t == (m & ~TT_W'(1)))        g = G_OR;
    else if (t == TT_W'(1))               g = G_NOR;
    else if (t == par)                    g = G_XOR;
    else if (t == (m ^ par))              g = G_XNOR;
    else                                  g = G_COMPLEX;
    return g;
  endfunction

  assign n_raw   = in_tdata[TT_W +: ARITY_W];
  assign n_clamp = (n_raw > ARITY_W'(MAX_INPUTS)) ? ARITY_W'(MAX_INPUTS) : n_raw;

  always_comb begin
    case (n_clamp)
      3'd0:    mask = 64'h1;
      3'd1:    mask = 64'h3;
      3'd2:    mask = 64'hF;
      3'd3:    mask = 64'hFF;
      3'd4:    mask = 64'hFFFF;
      3'd5:    mask = 64'hFFFF_FFFF;
      default: mask = '1;
    endcase
  end

  assign tt = in_tdata[TT_W-1:0] & mask;

  // No requests taken while the bucket heads are being cleared
  assign in_tready  = !clearing && !qstat.full;
  assign push       = in_tvalid && in_tready;
  assign item.tt    = tt;
  assign item.n     = n_clamp;
  assign item.gtype = classify(tt, n_clamp, mask);

endmodule

// ===== hdl/lfr_queue.sv =====
// Short FIFO between the classifier front end and the lookup back end.
// Depends on lfr_pkg.
module lfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lfr_pkg::lfr_item_t  item_in,
  input  logic                pop,
  output lfr_pkg::lfr_item_t  item_out,
  output lfr_pkg::lfr_qstat_t stat
);
  import lfr_pkg::*;

  lfr_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= item_in;
  end

  assign item_out   = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== hdl/lfr_back.sv =====
// Back end: hashes complex functions, walks the bucket chain, registers new entries,
// and holds the result register. Depends on lfr_pkg.
module lfr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfr_pkg::lfr_qstat_t            qstat,
  input  lfr_pkg::lfr_item_t             item,
  output logic                           pop,
  output logic                           clearing,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lfr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lfr_pkg::*;

  // Only the low HB_W bits of the 64-bit product reach the bucket index.
  localparam int HB_W = BKT_W + 29;
  localparam int LO_W = (HB_W + 1) / 2;
  localparam int HI_W = HB_W - LO_W;
  localparam logic [LO_W-1:0] C_LO = MUL_H[LO_W-1:0];
  localparam logic [LO_W-1:0] C_HI = LO_W'(MUL_H[HB_W-1:LO_W]);

  typedef struct packed {
    logic [LINK_W-1:0]  next;
    logic [ARITY_W-1:0] n;
    logic [TT_W-1:0]    tt;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_HEAD, S_HEADW, S_CMP, S_INS
  } state_t;

  ent_t              ent_mem [TABLE_DEPTH];
  logic [LINK_W-1:0] bh_mem  [BUCKET_COUNT];

  state_t            state_r, state_nxt;
  logic [BKT_W-1:0]  clr_r, clr_nxt;
  logic [LINK_W-1:0] count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  gate_t             gt_r, gt_nxt;
  logic [FID_W-1:0]  fid_r, fid_nxt;
  logic              idv_r, idv_nxt;
  logic              full_r, full_nxt;
  logic [TT_W-1:0]   tt_r, tt_nxt;
  logic [ARITY_W-1:0] n_r, n_nxt;
  logic [HB_W-1:0]   a_r, a_nxt;
  logic [2*LO_W-1:0] p0_r, p0_nxt;
  logic [HI_W-1:0]   p1_r, p1_nxt;
  logic [HI_W-1:0]   p2_r, p2_nxt;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;

  logic              bh_we, bh_re;
  logic [BKT_W-1:0]  bh_waddr, bh_raddr;
  logic [LINK_W-1:0] bh_wdata, bh_rd_r;
  logic              ent_we, ent_re;
  logic [ID_W-1:0]   ent_waddr, ent_raddr;
  ent_t              ent_wdata, ent_rd_r;

  logic [LO_W-1:0]   mul_a, mul_b;
  logic [2*LO_W-1:0] mul_p;
  logic [TT_W-1:0]   h0, h1;
  logic [HI_W-1:0]   p12;
  logic [HB_W-1:0]   h2;
  logic              out_free;

  // n times MUL_N modulo 2^64, as shifted adds over the three bits of n
  function automatic logic [TT_W-1:0] arity_mix(input logic [ARITY_W-1:0] n);
    logic [TT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < ARITY_W; k++) begin
      if (n[k]) acc = acc + (MUL_N << k);
    end
    return acc;
  endfunction

  assign mul_p    = mul_a * mul_b;
  assign h0       = item.tt ^ arity_mix(item.n);
  assign h1       = h0 ^ (h0 >> 32);
  assign p12      = p1_r + p2_r;
  assign h2       = HB_W'(p0_r) + {p12, {LO_W{1'b0}}};
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    gt_nxt        = gt_r;
    fid_nxt       = fid_r;
    idv_nxt       = idv_r;
    full_nxt      = full_r;
    tt_nxt        = tt_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    bkt_nxt       = bkt_r;
    cur_nxt       = cur_r;
    head_nxt      = head_r;
    pop           = 1'b0;
    mul_a         = a_r[LO_W-1:0];
    mul_b         = C_LO;
    bh_we         = 1'b0;
    bh_waddr      = bkt_r;
    bh_wdata      = count_r;
    bh_re         = 1'b0;
    bh_raddr      = bkt_r;
    ent_we        = 1'b0;
    ent_waddr     = count_r[ID_W-1:0];
    ent_wdata     = '{next: head_r, n: n_r, tt: tt_r};
    ent_re        = 1'b0;
    ent_raddr     = cur_r[ID_W-1:0];

    case (state_r)
      S_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_r;
        bh_wdata = NIL_LINK;
        clr_nxt  = clr_r + BKT_W'(1);
        if (clr_r == BKT_W'(BUCKET_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        // Output register is free for the whole life of the popped request
        if (!qstat.empty && out_free) begin
          pop = 1'b1;
          if (item.gtype != G_COMPLEX) begin
            out_valid_nxt = 1'b1;
            gt_nxt        = item.gtype;
            fid_nxt       = '0;
            idv_nxt       = 1'b0;
            full_nxt      = 1'b0;
          end else begin
            tt_nxt    = item.tt;
            n_nxt     = item.n;
            a_nxt     = h1[HB_W-1:0];
            state_nxt = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        p0_nxt    = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_b     = C_HI;
        p1_nxt    = mul_p[HI_W-1:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        mul_a     = LO_W'(a_r[HB_W-1:LO_W]);
        p2_nxt    = mul_p[HI_W-1:0];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        bkt_nxt   = h2[BKT_W-1:0] ^ h2[HB_W-1:29];
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        bh_re     = 1'b1;
        state_nxt = S_HEADW;
      end
      S_HEADW: begin
        cur_nxt  = bh_rd_r;
        head_nxt = bh_rd_r;
        if (bh_rd_r < count_r) begin
          ent_re    = 1'b1;
          ent_raddr = bh_rd_r[ID_W-1:0];
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_CMP: begin
        if (ent_rd_r.tt == tt_r && ent_rd_r.n == n_r) begin
          out_valid_nxt = 1'b1;
          gt_nxt        = G_COMPLEX;
          fid_nxt       = FID_W'(cur_r);
          idv_nxt       = 1'b1;
          full_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt = ent_rd_r.next;
          if (ent_rd_r.next < count_r) begin
            ent_re    = 1'b1;
            ent_raddr = ent_rd_r.next[ID_W-1:0];
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        out_valid_nxt = 1'b1;
        gt_nxt        = G_COMPLEX;
        state_nxt     = S_IDLE;
        if (count_r >= LINK_W'(TABLE_DEPTH)) begin
          fid_nxt  = '0;
          idv_nxt  = 1'b0;
          full_nxt = 1'b1;
        end else begin
          ent_we    = 1'b1;
          bh_we     = 1'b1;
          fid_nxt   = FID_W'(count_r);
          idv_nxt   = 1'b1;
          full_nxt  = 1'b0;
          count_nxt = count_r + LINK_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    gt_r   <= gt_nxt;
    fid_r  <= fid_nxt;
    idv_r  <= idv_nxt;
    full_r <= full_nxt;
    tt_r   <= tt_nxt;
    n_r    <= n_nxt;
    a_r    <= a_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    bkt_r  <= bkt_nxt;
    cur_r  <= cur_nxt;
    head_r <= head_nxt;
  end

  always_ff @(posedge clk) begin
    if (bh_we) bh_mem[bh_waddr] <= bh_wdata;
    if (bh_re) bh_rd_r <= bh_mem[bh_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_r <= ent_mem[ent_raddr];
  end

  assign clearing   = (state_r == S_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {full_r, idv_r, fid_r, gt_r};

endmodule

// ===== hdl/lfr_checker.sv =====
// Port-level checks on the registry results, bound to the top level.
// Depends on lfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [lfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lfr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lfr_pkg::*;

  logic [GT_W-1:0]  gt;
  logic [FID_W-1:0] fid;
  logic             idv;
  logic             tfull;
  logic             in_seen;

  assign gt      = out_tdata[GT_W-1:0];
  assign fid     = out_tdata[GT_W +: FID_W];
  assign idv     = out_tdata[GT_W + FID_W];
  assign tfull   = out_tdata[GT_W + FID_W + 1];
  assign in_seen = in_tvalid && in_tready && (in_tdata != '0);

  `LFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `LFR_ASSERT_IMPLY(a_gt_range, clk, rst_n, out_tvalid, gt <= G_COMPLEX)
  `LFR_ASSERT_IMPLY(a_id_or_full, clk, rst_n, out_tvalid, !(idv && tfull))
  `LFR_ASSERT_IMPLY(a_flags_complex, clk, rst_n, out_tvalid && (idv || tfull), gt == G_COMPLEX)
  `LFR_ASSERT_IMPLY(a_fid_zero, clk, rst_n, out_tvalid && !idv, fid == '0 || in_seen)

endmodule

bind logic_function_registry_unit lfr_checker u_lfr_checker (.*);
